/* sv/length_prefix_deframer_top_assert.svh */
// assertion macros for the length prefix deframer
// used by lpd_parser; no other dependencies
`ifndef LENGTH_PREFIX_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define LPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lpd_pkg.sv */
// shared types and constants for the length prefix deframer
// no dependencies
package lpd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 31;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;

endpackage

/* sv/lpd_in_stage.sv */
// input register stage of the length prefix deframer
// depends on lpd_pkg
module lpd_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lpd_pkg::byte_t s_tdata,
    output logic          in_valid,
    output lpd_pkg::byte_t in_data,
    input  logic          in_take
);
    import lpd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    byte_t data_reg;

    // register refills whenever it is empty or being drained
    assign s_tready = !valid_reg || in_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;

endmodule

/* sv/lpd_parser.sv */
// prefix parser, payload counter and result register of the deframer
// depends on lpd_pkg and length_prefix_deframer_top_assert.svh
`include "length_prefix_deframer_top_assert.svh"

module lpd_parser #(
    parameter int HEADER_BYTES = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  lpd_pkg::byte_t in_data,
    output logic           in_take,
    output logic           m_tvalid,
    input  logic           m_tready,
    output lpd_pkg::byte_t m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);
    import lpd_pkg::*;

    localparam int FULL_W = BYTE_W * HEADER_BYTES;
    localparam int HDR_W  = BYTE_W * (HEADER_BYTES - 1);
    localparam int HCNT_W = $clog2(HEADER_BYTES);
    localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HEADER_BYTES - 1);

    logic [HCNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [HDR_W-1:0]  hdr_bytes_reg, hdr_bytes_next;
    len_t              msg_len_reg, msg_len_next;
    len_t              pay_cnt_reg, pay_cnt_next;
    logic              dead_reg, dead_next;
    logic              out_valid_reg, out_valid_next;
    byte_t             out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_err_reg, out_err_next;

    logic [FULL_W-1:0] full_prefix;
    len_t              len_from_prefix;
    len_t              pay_cnt_inc;
    logic              advance;
    logic              load_out;

    // an item moves on when the result register can take a beat
    assign advance = in_valid && (!out_valid_reg || m_tready);
    assign in_take = advance;

    assign full_prefix = {hdr_bytes_reg, in_data};
    assign pay_cnt_inc = pay_cnt_reg + 1'b1;

    // non-negative prefix, saturated to the length register
    if (FULL_W - 1 > LEN_W) begin : g_sat
        assign len_from_prefix = (|full_prefix[FULL_W-2:LEN_W]) ? LEN_MAX
                                                                : full_prefix[LEN_W-1:0];
    end else begin : g_fit
        assign len_from_prefix = LEN_W'(full_prefix[FULL_W-2:0]);
    end

    // next state and result
    always_comb begin
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_bytes_next = hdr_bytes_reg;
        msg_len_next   = msg_len_reg;
        pay_cnt_next   = pay_cnt_reg;
        dead_next      = dead_reg;
        load_out       = 1'b0;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (advance && !dead_reg) begin
            if (msg_len_reg != '0) begin
                // payload beat
                load_out      = 1'b1;
                out_data_next = in_data;
                out_err_next  = 1'b0;
                out_last_next = (pay_cnt_inc >= msg_len_reg);
                if (pay_cnt_inc >= msg_len_reg) begin
                    msg_len_next = '0;
                    pay_cnt_next = '0;
                end else begin
                    pay_cnt_next = pay_cnt_inc;
                end
            end else if (hdr_cnt_reg != HCNT_LAST) begin
                // early prefix byte
                hdr_bytes_next = full_prefix[HDR_W-1:0];
                hdr_cnt_next   = hdr_cnt_reg + 1'b1;
            end else begin
                // final prefix byte
                hdr_cnt_next   = '0;
                hdr_bytes_next = '0;
                pay_cnt_next   = '0;
                if (full_prefix[FULL_W-1]) begin
                    dead_next     = 1'b1;
                    msg_len_next  = '0;
                    load_out      = 1'b1;
                    out_data_next = '0;
                    out_last_next = 1'b0;
                    out_err_next  = 1'b1;
                end else begin
                    msg_len_next = len_from_prefix;
                end
            end
        end
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg   <= '0;
            hdr_bytes_reg <= '0;
            msg_len_reg   <= '0;
            pay_cnt_reg   <= '0;
            dead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            hdr_cnt_reg   <= hdr_cnt_next;
            hdr_bytes_reg <= hdr_bytes_next;
            msg_len_reg   <= msg_len_next;
            pay_cnt_reg   <= pay_cnt_next;
            dead_reg      <= dead_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    // checks
    `LPD_ASSERT_IMPLY(a_err_no_payload, out_valid_reg && out_err_reg,
        (out_data_reg == '0) && !out_last_reg, "sync error beat carries payload")
    `LPD_ASSERT_NEXT(a_dead_sticky, dead_reg, dead_reg, "dead link came back up")
    `LPD_ASSERT_NEXT(a_dead_silent, dead_reg && (!out_valid_reg || m_tready),
        !out_valid_reg, "result produced on a dead link")
    `LPD_ASSERT_IMPLY(a_count_below_len, msg_len_reg != '0,
        pay_cnt_reg < msg_len_reg, "payload count reached message length")
    `LPD_ASSERT_IMPLY(a_no_hdr_in_payload, msg_len_reg != '0,
        hdr_cnt_reg == '0, "prefix count moved during payload")

endmodule

/* sv/length_prefix_deframer_top.sv */
// top level of the length prefix deframer
// depends on lpd_pkg, lpd_in_stage and lpd_parser
//
// usage:
//   s_ channel takes the received link stream, one byte per beat in s_tdata.
//   each message is a HEADER_BYTES big-endian length prefix and then that
//   many payload bytes. m_ channel gives payload bytes in m_tdata, with
//   m_tlast on the byte that completes a message. zero-length messages
//   give no beat. a prefix with its top bit set gives one beat with
//   m_tuser high and m_tdata, m_tlast zero; after that every byte is
//   taken and dropped until reset.
//   a payload byte passes through the input register and then the result
//   register on its way from s_ to m_.
//   throughput: one byte per cycle while m_tready stays high, set by the
//   parser step between those two registers.
//   reset (aresetn low, synchronous) empties both registers, clears the
//   prefix and payload counters and brings the link up.
//   when m_tready is low the result beat holds; the input register still
//   takes one more byte, then s_tready drops until the result drains.
module length_prefix_deframer_top #(
    parameter int HEADER_BYTES = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  lpd_pkg::byte_t s_tdata,   // [7:0] data_byte
    output logic           m_tvalid,
    input  logic           m_tready,
    output lpd_pkg::byte_t m_tdata,   // [7:0] payload_byte
    output logic           m_tlast,   // last_of_message
    output logic           m_tuser    // [0] sync_error
);
    import lpd_pkg::*;

    logic  in_valid;
    byte_t in_data;
    logic  in_take;

    // input register
    lpd_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_take  (in_take)
    );

    // prefix parser and result register
    lpd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_take  (in_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/tb_length_prefix_deframer_top.sv */
// self-checking testbench for length_prefix_deframer_top
// depends on lpd_pkg and the deframer rtl; drives framed byte streams and checks
// every m_ beat against an in-bench model of the deframer
module tb_length_prefix_deframer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int HDR        = 4;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        byte_t data;
        logic  last;
        logic  err;
    } out_beat_t;

    // model of the deframer plus the queue of beats it still owes
    class deframe_scoreboard;
        logic [2:0]           hdr_cnt;
        logic [8*(HDR-1)-1:0] hdr_bytes;
        len_t                 msg_len;
        len_t                 pay_cnt;
        bit                   dead;
        out_beat_t            owed_beats[$];
        int                   errors;

        function new();
            hdr_cnt   = '0;
            hdr_bytes = '0;
            msg_len   = '0;
            pay_cnt   = '0;
            dead      = 1'b0;
            errors    = 0;
        endfunction

        // advance the model by one accepted link byte
        function void note_byte(byte_t b);
            logic [8*HDR-1:0] full;
            out_beat_t        beat;
            if (dead)
                return;
            // payload byte passes straight through
            if (msg_len != 0) begin
                pay_cnt   = pay_cnt + 1'b1;
                beat.data = b;
                beat.last = 1'b0;
                beat.err  = 1'b0;
                if (pay_cnt >= msg_len) begin
                    beat.last = 1'b1;
                    msg_len   = '0;
                    pay_cnt   = '0;
                end
                owed_beats.push_back(beat);
                return;
            end
            // collect the prefix, most significant byte first
            if (int'(hdr_cnt) + 1 < HDR) begin
                hdr_bytes = {hdr_bytes[8*(HDR-2)-1:0], b};
                hdr_cnt   = hdr_cnt + 1'b1;
                return;
            end
            full      = {hdr_bytes, b};
            hdr_cnt   = '0;
            hdr_bytes = '0;
            pay_cnt   = '0;
            if (full[8*HDR-1]) begin
                dead      = 1'b1;
                msg_len   = '0;
                beat.data = '0;
                beat.last = 1'b0;
                beat.err  = 1'b1;
                owed_beats.push_back(beat);
            end else begin
                full[8*HDR-1] = 1'b0;
                // lengths beyond the counter width saturate
                if (full > {{(8*HDR-LEN_W){1'b0}}, LEN_MAX})
                    msg_len = LEN_MAX;
                else
                    msg_len = full[LEN_W-1:0];
            end
        endfunction

        // compare one m_ beat with the oldest owed beat
        function void check_beat(byte_t data, logic last, logic err);
            out_beat_t want;
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected beat data=%h last=%b user=%b",
                         $time, data, last, err);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if (data !== want.data) begin
                $display("%0t: m_tdata expected %h actual %h", $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: m_tlast expected %b actual %b", $time, want.last, last);
                errors++;
            end
            if (err !== want.err) begin
                $display("%0t: m_tuser expected %b actual %b", $time, want.err, err);
                errors++;
            end
        endfunction

        function int owed_count();
            return owed_beats.size();
        endfunction
    endclass

    logic  aclk     = 1'b0;
    logic  aresetn  = 1'b0;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    byte_t s_tdata  = '0;
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    byte_t m_tdata;
    logic  m_tlast;
    logic  m_tuser;

    deframe_scoreboard sb = new();

    int unsigned bytes_sent  = 0;
    int unsigned tx_gap_pct  = 0;
    bit          quiet       = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned idle_cycles = 0;

    length_prefix_deframer_top #(
        .HEADER_BYTES(HDR)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // beat monitor: feeds the model and checks results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tlast, m_tuser);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts and one long hold-off on request
    initial begin
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // offer one byte and hold it until taken, then maybe idle
    task automatic put_byte(input byte_t b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
        if (!quiet && $urandom_range(1, 100) <= tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // four-byte big-endian length prefix
    task automatic put_prefix(input logic [8*HDR-1:0] prefix);
        for (int i = HDR - 1; i >= 0; i--)
            put_byte(prefix[8*i +: 8]);
    endtask

    task automatic put_frame(input int unsigned len);
        put_prefix(len);
        for (int unsigned i = 0; i < len; i++)
            put_byte(byte_t'($urandom_range(0, 255)));
    endtask

    // stop sending until the block has delivered everything owed
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_count() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int unsigned len;
        int unsigned sel;
        logic [8*HDR-1:0] bad_prefix;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one-byte frame, byte extremes, empty frame
        put_prefix(1);
        put_byte(8'h00);
        put_prefix(2);
        put_byte(8'hFF);
        put_byte(8'hAA);
        put_prefix(0);
        put_prefix(3);
        put_byte(8'h55);
        put_byte(8'h01);
        put_byte(8'h80);
        drain();

        // random frames, mostly short, some empty, a few longer
        while (bytes_sent < 640) begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0: tx_gap_pct = 0;
                1: tx_gap_pct = 15;
                default: tx_gap_pct = 50;
            endcase
            if (sel < 10)
                len = 0;
            else if (sel < 88)
                len = $urandom_range(1, 24);
            else
                len = $urandom_range(25, 300);

            // fill the pipe while the receiver holds off
            if (bytes_sent > 300 && bytes_sent < 340 && !rx_hold_req) begin
                rx_hold_req = 1'b1;
                tx_gap_pct  = 0;
                len         = 60;
            end
            put_frame(len);
            if (bytes_sent > 500 && bytes_sent < 560)
                drain();
        end

        // one frame whose length uses the second prefix byte
        tx_gap_pct = 5;
        put_frame(32'h0000_0103);

        // closing part without idling: a few frames, a negative prefix, dropped bytes
        drain();
        quiet      = 1'b1;
        tx_gap_pct = 0;
        repeat (3) put_frame($urandom_range(0, 10));
        bad_prefix = {1'b1, 31'($urandom())};
        put_prefix(bad_prefix);
        repeat (16) put_byte(byte_t'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (sb.owed_count() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (sb.errors == 0 && sb.owed_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
